/* hdl/tbpg_pkg.sv */
package tbpg_pkg;

    localparam int VIDEO_ADDR_BITS = 14;
    localparam int VMEM_DEPTH      = 1 << VIDEO_ADDR_BITS;
    localparam int CFG_ADDR_BITS   = 3;

    // Register indexes (byte address / 4)
    localparam logic REG_NAMETABLE = 1'b0;
    localparam logic REG_PATTERN   = 1'b1;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR,
        ST_TILE,
        ST_ATTR,
        ST_PLO,
        ST_PHI
    } t_state;

    localparam logic [23:0] COLOUR_TABLE [64] = '{
        24'h808080, 24'h003DA6, 24'h0012B0, 24'h440096,
        24'hA1005E, 24'hC70028, 24'hBA0600, 24'h8C1700,
        24'h5C2F00, 24'h104500, 24'h054A00, 24'h00472E,
        24'h004166, 24'h000000, 24'h050505, 24'h050505,
        24'hC7C7C7, 24'h0077FF, 24'h2155FF, 24'h8237FA,
        24'hEB2FB5, 24'hFF2950, 24'hFF2200, 24'hD63200,
        24'hC46200, 24'h358000, 24'h058F00, 24'h008A55,
        24'h0099CC, 24'h212121, 24'h090909, 24'h090909,
        24'hFFFFFF, 24'h0FD7FF, 24'h69A2FF, 24'hD480FF,
        24'hFF45F3, 24'hFF618B, 24'hFF8833, 24'hFF9C12,
        24'hFABC20, 24'h9FE30E, 24'h2BF035, 24'h0CF0A4,
        24'h05FBFF, 24'h5E5E5E, 24'h0D0D0D, 24'h0D0D0D,
        24'hFFFFFF, 24'hA6FCFF, 24'hB3ECFF, 24'hDAABEB,
        24'hFFA8F9, 24'hFFABB3, 24'hFFD2B0, 24'hFFEFA6,
        24'hFFF79C, 24'hD7E895, 24'hA6EDAF, 24'hA2F2DA,
        24'h99FFFC, 24'hDDDDDD, 24'h111111, 24'h111111
    };

endpackage

/* hdl/tile_background_pixel_generator.sv */
// Channel   | Direction | Handshake                | Payload
// ----------+-----------+--------------------------+------------------------------------------
// item in   | input     | i_in_valid / o_in_ready  | i_command, i_address, i_write_data,
//           |           |                          | i_pixel_x, i_pixel_y
// result    | output    | o_out_valid / i_out_ready| o_rgb, o_color_index
// config    | input     | APB psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// A render makes four reads (tile, attribute, two bitplanes), one after another, through the
// single port of the video memory. A write uses the same port.
// The result enters the queue from the finish stage after the last bitplane read; a 2-entry result
// queue lets the next item start while a result waits.
// Reset (synchronous, i_rst_n low) clears the sequencer, the queue and both registers; the
// video memory is not cleared. A full queue, counting the result in the finish stage, holds the input.
module tile_background_pixel_generator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_command,
    input  logic [tbpg_pkg::VIDEO_ADDR_BITS-1:0] i_address,
    input  logic [7:0]                           i_write_data,
    input  logic [7:0]                           i_pixel_x,
    input  logic [7:0]                           i_pixel_y,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [23:0]                          o_rgb,
    output logic [3:0]                           o_color_index,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tbpg_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import tbpg_pkg::*;

    // configuration
    logic [1:0] r_nt_sel;
    logic       r_pat_sel;

    // sequencer
    t_state r_state, n_state;

    // current item
    logic [VIDEO_ADDR_BITS-1:0] r_addr;
    logic [7:0]                 r_wdata;
    logic [7:0]                 r_x;
    logic [7:0]                 r_y;
    logic [7:0]                 r_tile;
    logic [1:0]                 r_pal;

    // finish stage
    logic       r_pend;
    logic [7:0] r_fin_p0;
    logic [2:0] r_fin_sel;
    logic [1:0] r_fin_pal;
    logic [3:0] w_cidx;

    // memory
    logic [7:0]                 r_vmem [VMEM_DEPTH];
    logic [7:0]                 r_rdata;
    logic [VIDEO_ADDR_BITS-1:0] w_maddr;
    logic                       w_we;
    logic                       w_re;

    // result queue
    logic [1:0] r_cnt;
    logic [3:0] r_q0;
    logic [3:0] r_q1;
    logic       w_pop;
    logic       w_room;
    logic       w_accept;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nt_sel  <= 2'd0;
            r_pat_sel <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_NAMETABLE: r_nt_sel  <= pwdata[1:0];
                REG_PATTERN:   r_pat_sel <= pwdata[0];
                default:       r_nt_sel  <= r_nt_sel;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_NAMETABLE: prdata = {30'd0, r_nt_sel};
            REG_PATTERN:   prdata = {31'd0, r_pat_sel};
            default:       prdata = 32'd0;
        endcase
    end

    // ---------------- sequencer ----------------
    // Room for one more result counting the one in the finish stage
    assign w_room   = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && !r_pend);
    assign w_accept = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE, ST_WR: begin
                if (i_in_valid) begin
                    n_state = (i_command == CMD_RENDER) ? ST_TILE : ST_WR;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_TILE: n_state = ST_ATTR;
            ST_ATTR: n_state = ST_PLO;
            ST_PLO:  n_state = ST_PHI;
            ST_PHI: begin
                if (w_room) begin
                    if (i_in_valid) begin
                        n_state = (i_command == CMD_RENDER) ? ST_TILE : ST_WR;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_we       = 1'b0;
        w_re       = 1'b0;
        w_maddr    = r_addr;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_WR: begin
                w_we       = 1'b1;
                o_in_ready = 1'b1;
            end
            ST_TILE: begin
                w_re    = 1'b1;
                w_maddr = {2'b10, r_nt_sel, r_y[7:3], r_x[7:3]};
            end
            ST_ATTR: begin
                w_re    = 1'b1;
                w_maddr = {2'b10, r_nt_sel, 4'b1111, r_y[7:5], r_x[7:5]};
            end
            ST_PLO: begin
                w_re    = 1'b1;
                w_maddr = {1'b0, r_pat_sel, r_tile, 1'b0, r_y[2:0]};
            end
            ST_PHI: begin
                // hold the read while the queue is full so plane 0 stays in r_rdata
                w_re       = w_room;
                w_maddr    = {1'b0, r_pat_sel, r_tile, 1'b1, r_y[2:0]};
                o_in_ready = w_room;
            end
            default: w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= (r_state == ST_PHI) && w_room;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_addr  <= i_address;
            r_wdata <= i_write_data;
            r_x     <= i_pixel_x;
            r_y     <= i_pixel_y;
        end
        if (r_state == ST_ATTR) begin
            r_tile <= r_rdata;
        end
        if (r_state == ST_PLO) begin
            r_pal <= r_rdata[{r_y[4], r_x[4], 1'b0} +: 2];
        end
        if ((r_state == ST_PHI) && w_room) begin
            r_fin_p0  <= r_rdata;
            r_fin_sel <= ~r_x[2:0];
            r_fin_pal <= r_pal;
        end
    end

    // ---------------- video memory ----------------
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_vmem[w_maddr] <= r_wdata;
        end else if (w_re) begin
            r_rdata <= r_vmem[w_maddr];
        end
    end

    // ---------------- finish and result queue ----------------
    assign w_cidx = {r_fin_pal, r_rdata[r_fin_sel], r_fin_p0[r_fin_sel]};
    assign w_pop  = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, r_pend} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend && w_pop) begin
            if (r_cnt == 2'd1) begin
                r_q0 <= w_cidx;
            end else begin
                r_q0 <= r_q1;
                r_q1 <= w_cidx;
            end
        end else if (r_pend) begin
            if (r_cnt == 2'd0) begin
                r_q0 <= w_cidx;
            end else begin
                r_q1 <= w_cidx;
            end
        end else if (w_pop) begin
            r_q0 <= r_q1;
        end
    end

    assign o_out_valid   = (r_cnt != 2'd0);
    assign o_color_index = r_q0;
    assign o_rgb         = COLOUR_TABLE[{2'b00, r_q0}];

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue count out of range");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_cnt != 2'd2) || w_pop)
        else $error("result pushed into a full queue");

    a_port_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_re))
        else $error("memory read and write in the same cycle");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_TILE) || (r_state == ST_WR))
        else $error("accepted item did not start");

    a_render_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_PHI) && w_room) |=> r_pend)
        else $error("last bitplane read not followed by finish");
`endif

endmodule
